// ----- design/utf8cd_pkg.sv -----
// types, constants and helper functions for the utf-8 codepoint decoder
`default_nettype none

package utf8cd_pkg;

  localparam int CP_W = 21;
  localparam int QDEPTH = 4;
  localparam int QIDX_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int MAX_RES = 3;
  localparam int RESN_W = $clog2(MAX_RES + 1);

  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;

  localparam logic [1:0] NEED_NONE = 2'd0;
  localparam logic [1:0] NEED_ONE = 2'd1;
  localparam logic [1:0] NEED_TWO = 2'd2;
  localparam logic [1:0] NEED_THREE = 2'd3;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic raw;
    logic fin;
  } res_t;

  // continuation bytes a lead asks for, none for a non-lead
  function automatic logic [1:0] lead_need(input logic [7:0] b);
    logic [1:0] n;
    n = NEED_NONE;
    if ((b & ASCII_MASK) == 8'h00) n = NEED_NONE;
    else if ((b & LEAD2_MASK) == LEAD2_CODE) n = NEED_ONE;
    else if ((b & LEAD3_MASK) == LEAD3_CODE) n = NEED_TWO;
    else if ((b & LEAD4_MASK) == LEAD4_CODE) n = NEED_THREE;
    return n;
  endfunction

  function automatic logic [CP_W-1:0] cp_raw(input logic [7:0] b);
    return {{(CP_W-8){1'b0}}, b};
  endfunction

  function automatic logic [CP_W-1:0] cp2(input logic [7:0] a, input logic [7:0] b);
    return {{(CP_W-11){1'b0}}, a[4:0], b[5:0]};
  endfunction

  function automatic logic [CP_W-1:0] cp3(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c);
    return {{(CP_W-16){1'b0}}, a[3:0], b[5:0], c[5:0]};
  endfunction

  function automatic logic [CP_W-1:0] cp4(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c, input logic [7:0] d);
    return {a[2:0], b[5:0], c[5:0], d[5:0]};
  endfunction

endpackage

`default_nettype wire

// ----- design/utf8_codepoint_decoder.sv -----
// utf-8 codepoint decoder: byte stream in, codepoints out through a four-entry result queue
//
//   channel | handshake          | payload
//   --------+--------------------+--------------------------------------------
//   in      | in_valid/in_stall  | byte_value[7:0], string_end
//   out     | out_valid/out_stall| codepoint[20:0], raw_lead, final_of_string
//
// one byte per cycle while in_stall is low; decode is one combinational pass from byte and state into the queue
// a byte gives zero to three results; in_stall rises while the queue holds two or more
// a truncated string end that yields three results stalls input until the queue holds fewer than two
// out_valid comes from the queue count only; the queue drains one result per cycle while out_stall is low
// rst is synchronous active high and empties the queue and clears the open sequence
`default_nettype none

module utf8_codepoint_decoder (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  byte_value,
  input  wire         string_end,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [20:0] codepoint,
  output logic        raw_lead,
  output logic        final_of_string
);

  logic [1:0] need, need_next;
  logic [7:0] held_lead, held_lead_next;
  logic [7:0] held_followers [2];
  logic [1:0] followers_held, followers_held_next;
  logic       store_follower;

  utf8cd_pkg::res_t q [utf8cd_pkg::QDEPTH];
  utf8cd_pkg::res_t q_next [utf8cd_pkg::QDEPTH];
  logic [utf8cd_pkg::QCNT_W-1:0] cnt, cnt_next, base;

  utf8cd_pkg::res_t res [utf8cd_pkg::MAX_RES];
  logic [utf8cd_pkg::RESN_W-1:0] res_n;

  logic in_acc, pop;
  logic [1:0] lead_len_need, f0_need;
  logic c_is_lead;

  assign in_stall = (cnt > utf8cd_pkg::QCNT_W'(1));
  assign in_acc = in_valid && !in_stall;
  assign out_valid = (cnt != '0);
  assign pop = out_valid && !out_stall;
  assign codepoint = q[0].cp;
  assign raw_lead = q[0].raw;
  assign final_of_string = q[0].fin;

  assign lead_len_need = utf8cd_pkg::lead_need(held_lead);
  assign f0_need = utf8cd_pkg::lead_need(held_followers[0]);
  assign c_is_lead = (utf8cd_pkg::lead_need(byte_value) != utf8cd_pkg::NEED_NONE);

  // decode one byte against the open sequence
  always_comb begin
    need_next = need;
    held_lead_next = held_lead;
    followers_held_next = followers_held;
    store_follower = 1'b0;
    res_n = '0;
    for (int j = 0; j < utf8cd_pkg::MAX_RES; j++) begin
      res[j] = '{cp: utf8cd_pkg::cp_raw(byte_value), raw: 1'b0, fin: 1'b0};
    end
    if (need == utf8cd_pkg::NEED_NONE) begin
      if (string_end) begin
        res[0] = '{cp: utf8cd_pkg::cp_raw(byte_value), raw: c_is_lead, fin: 1'b1};
        res_n = utf8cd_pkg::RESN_W'(1);
      end else if (!c_is_lead) begin
        res[0] = '{cp: utf8cd_pkg::cp_raw(byte_value), raw: 1'b0, fin: 1'b0};
        res_n = utf8cd_pkg::RESN_W'(1);
      end else begin
        held_lead_next = byte_value;
        need_next = utf8cd_pkg::lead_need(byte_value);
        followers_held_next = 2'd0;
      end
    end else if (need == utf8cd_pkg::NEED_ONE) begin
      case (lead_len_need)
        utf8cd_pkg::NEED_ONE:
          res[0].cp = utf8cd_pkg::cp2(held_lead, byte_value);
        utf8cd_pkg::NEED_TWO:
          res[0].cp = utf8cd_pkg::cp3(held_lead, held_followers[0], byte_value);
        default:
          res[0].cp = utf8cd_pkg::cp4(held_lead, held_followers[0], held_followers[1],
                                      byte_value);
      endcase
      res[0].raw = 1'b0;
      res[0].fin = string_end;
      res_n = utf8cd_pkg::RESN_W'(1);
      need_next = utf8cd_pkg::NEED_NONE;
      followers_held_next = 2'd0;
    end else if (string_end) begin
      // truncated: lead goes out raw, held bytes decode again as a fresh tail
      res[0] = '{cp: utf8cd_pkg::cp_raw(held_lead), raw: 1'b1, fin: 1'b0};
      need_next = utf8cd_pkg::NEED_NONE;
      followers_held_next = 2'd0;
      if (followers_held == 2'd0) begin
        res[1] = '{cp: utf8cd_pkg::cp_raw(byte_value), raw: c_is_lead, fin: 1'b1};
        res_n = utf8cd_pkg::RESN_W'(2);
      end else if (f0_need == utf8cd_pkg::NEED_ONE) begin
        res[1] = '{cp: utf8cd_pkg::cp2(held_followers[0], byte_value), raw: 1'b0,
                   fin: 1'b1};
        res_n = utf8cd_pkg::RESN_W'(2);
      end else begin
        res[1] = '{cp: utf8cd_pkg::cp_raw(held_followers[0]),
                   raw: (f0_need != utf8cd_pkg::NEED_NONE), fin: 1'b0};
        res[2] = '{cp: utf8cd_pkg::cp_raw(byte_value), raw: c_is_lead, fin: 1'b1};
        res_n = utf8cd_pkg::RESN_W'(3);
      end
    end else begin
      store_follower = 1'b1;
      followers_held_next = followers_held + 2'd1;
      need_next = need - 2'd1;
    end
  end

  // result queue: head shifts out, new results land after the survivors
  always_comb begin
    base = cnt - utf8cd_pkg::QCNT_W'(pop);
    for (int k = 0; k < utf8cd_pkg::QDEPTH; k++) begin
      q_next[k] = q[k];
    end
    if (pop) begin
      for (int k = 0; k < utf8cd_pkg::QDEPTH - 1; k++) begin
        q_next[k] = q[k + 1];
      end
    end
    cnt_next = base;
    if (in_acc) begin
      for (int j = 0; j < utf8cd_pkg::MAX_RES; j++) begin
        if (utf8cd_pkg::RESN_W'(j) < res_n) begin
          q_next[utf8cd_pkg::QIDX_W'(base + utf8cd_pkg::QCNT_W'(j))] = res[j];
        end
      end
      cnt_next = base + utf8cd_pkg::QCNT_W'(res_n);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      need <= utf8cd_pkg::NEED_NONE;
      held_lead <= 8'h00;
      followers_held <= 2'd0;
    end else begin
      cnt <= cnt_next;
      if (in_acc) begin
        need <= need_next;
        held_lead <= held_lead_next;
        followers_held <= followers_held_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < utf8cd_pkg::QDEPTH; k++) begin
      q[k] <= q_next[k];
    end
    if (in_acc && store_follower) begin
      held_followers[followers_held[0]] <= byte_value;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= utf8cd_pkg::QCNT_W'(utf8cd_pkg::QDEPTH))
    else $error("result queue overflow");

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_acc && string_end) |-> (res_n != '0))
    else $error("string end produced no result");

  a_end_closes_seq: assert property (@(posedge clk) disable iff (rst)
    (in_acc && string_end) |=> (need == utf8cd_pkg::NEED_NONE && followers_held == 2'd0))
    else $error("sequence left open after string end");

  a_seq_consistent: assert property (@(posedge clk) disable iff (rst)
    (need != utf8cd_pkg::NEED_NONE) |->
      (({1'b0, need} + {1'b0, followers_held}) == {1'b0, lead_len_need}))
    else $error("held byte count disagrees with lead");

endmodule

`default_nettype wire

// ----- tb/utf8cd_checker.sv -----
// watches both channels of the utf-8 decoder, predicts each result and compares
`default_nettype none

module utf8cd_checker (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  input  wire        in_stall,
  input  wire [7:0]  byte_value,
  input  wire        string_end,
  input  wire        out_valid,
  input  wire        out_stall,
  input  wire [20:0] codepoint,
  input  wire        raw_lead,
  input  wire        final_of_string,
  output int         errors,
  output int         outstanding
);

  utf8cd_pkg::res_t expected_cps[$];
  utf8cd_pkg::res_t want;
  logic [1:0] need;
  logic [7:0] lead_byte;
  logic [1:0][7:0] followers;
  int unsigned nfollow;
  logic [3:0][7:0] seq;
  int unsigned seq_n;
  int unsigned k;
  int unsigned results_seen;

  function automatic int unsigned seq_bytes(input logic [7:0] c);
    if ((c & utf8cd_pkg::ASCII_MASK) == 8'h00) return 1;
    if ((c & utf8cd_pkg::LEAD2_MASK) == utf8cd_pkg::LEAD2_CODE) return 2;
    if ((c & utf8cd_pkg::LEAD3_MASK) == utf8cd_pkg::LEAD3_CODE) return 3;
    if ((c & utf8cd_pkg::LEAD4_MASK) == utf8cd_pkg::LEAD4_CODE) return 4;
    return 1;
  endfunction

  function automatic logic [20:0] join_bytes(input logic [3:0][7:0] b, input int unsigned p,
                                             input int unsigned len);
    logic [31:0] acc;
    int unsigned i;
    case (len)
      2: acc = {24'h0, b[p] & 8'h1F};
      3: acc = {24'h0, b[p] & 8'h0F};
      default: acc = {24'h0, b[p] & 8'h07};
    endcase
    for (i = 1; i < len; i++) acc = (acc << 6) | {26'h0, b[p+i][5:0]};
    return acc[20:0];
  endfunction

  task automatic push_cp(input logic [20:0] cp, input logic raw, input logic fin);
    utf8cd_pkg::res_t r;
    r.cp = cp;
    r.raw = raw;
    r.fin = fin;
    expected_cps.push_back(r);
  endtask

  // decode the bytes as a whole string that ends after the last one
  task automatic decode_tail(input logic [3:0][7:0] b, input int unsigned n);
    int unsigned p, len;
    p = 0;
    while (p < n) begin
      len = seq_bytes(b[p]);
      if (len == 1) begin
        push_cp({13'h0, b[p]}, 1'b0, p + 1 == n);
        p = p + 1;
      end else if (p + len <= n) begin
        push_cp(join_bytes(b, p, len), 1'b0, p + len == n);
        p = p + len;
      end else begin
        push_cp({13'h0, b[p]}, 1'b1, p + 1 == n);
        p = p + 1;
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at result %0d: %s", results_seen, what);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      need = utf8cd_pkg::NEED_NONE;
      lead_byte = 8'h00;
      nfollow = 0;
      expected_cps.delete();
      errors = 0;
      results_seen = 0;
    end else begin
      // output first: a result leaving now was never caused by a byte taken now
      if (out_valid && !out_stall) begin
        if (expected_cps.size() == 0) begin
          report_mismatch($sformatf("unexpected codepoint %06h", codepoint));
        end else begin
          want = expected_cps.pop_front();
          if (codepoint !== want.cp)
            report_mismatch($sformatf("codepoint %06h, expected %06h", codepoint, want.cp));
          if (raw_lead !== want.raw)
            report_mismatch($sformatf("raw_lead %b, expected %b", raw_lead, want.raw));
          if (final_of_string !== want.fin)
            report_mismatch($sformatf("final_of_string %b, expected %b",
                                      final_of_string, want.fin));
        end
        results_seen++;
      end
      if (in_valid && !in_stall) begin
        if (need == utf8cd_pkg::NEED_NONE) begin
          if (string_end) begin
            seq = '0;
            seq[0] = byte_value;
            decode_tail(seq, 1);
          end else if (seq_bytes(byte_value) == 1) begin
            push_cp({13'h0, byte_value}, 1'b0, 1'b0);
          end else begin
            lead_byte = byte_value;
            need = 2'(seq_bytes(byte_value) - 1);
            nfollow = 0;
          end
        end else if (need == utf8cd_pkg::NEED_ONE || string_end) begin
          seq = '0;
          seq[0] = lead_byte;
          seq_n = 1;
          for (k = 0; k < nfollow; k++) begin
            seq[seq_n] = followers[k];
            seq_n++;
          end
          seq[seq_n] = byte_value;
          seq_n++;
          need = utf8cd_pkg::NEED_NONE;
          nfollow = 0;
          if (string_end) decode_tail(seq, seq_n);
          else push_cp(join_bytes(seq, 0, seq_n), 1'b0, 1'b0);
        end else begin
          followers[nfollow] = byte_value;
          nfollow++;
          need = need - 2'd1;
        end
      end
    end
    outstanding = expected_cps.size();
  end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// top of the utf-8 decoder testbench: clock, reset, byte stimulus, result stalls, verdict
`default_nettype none

module testbench;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  byte_value = 8'h00;
  logic        string_end = 1'b0;
  logic        out_stall = 1'b0;
  wire         in_stall;
  wire         out_valid;
  wire  [20:0] codepoint;
  wire         raw_lead;
  wire         final_of_string;
  int          errors;
  int          outstanding;

  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit hold_request = 1'b0;
  int sent = 0;

  // {string_end, byte}
  logic [8:0] directed [24] = '{
    9'h100, 9'h07F, 9'h080, 9'h0FF, 9'h1F8,
    9'h0C3, 9'h1A9,
    9'h0E2, 9'h082, 9'h0AC,
    9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,
    9'h0C0, 9'h0E0,
    9'h0C0, 9'h180,
    9'h1E2,
    9'h0F0, 9'h041, 9'h1E2,
    9'h0E2, 9'h1C3
  };

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  utf8_codepoint_decoder i_dut (.*);

  utf8cd_checker i_checker (.*);

  initial begin
    #200000;
    $display("[utf8_codepoint_decoder] ERROR");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
      end else begin
        out_stall <= !rx_quiet && ($urandom_range(99) < 35);
      end
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic e);
    if (!tx_quiet && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_value <= b;
    string_end <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  function automatic logic [7:0] follower();
    if ($urandom_range(9) == 0) return 8'($urandom_range(0, 255));
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  initial begin
    logic [7:0] chars[$];
    int unsigned pick, nsend, i;
    bit hold_given, drained;
    logic last_end;
    hold_given = 1'b0;
    drained = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[j]) put_byte(directed[j][7:0], directed[j][8]);

    while (sent < 524) begin
      tx_quiet = (sent >= 150 && sent < 200) || (sent >= 350 && sent < 450);
      rx_quiet = (sent >= 350 && sent < 450);
      if (sent >= 150 && !hold_given) begin
        hold_given = 1'b1;
        hold_request = 1'b1;
      end
      if (sent >= 300 && !drained) begin
        drained = 1'b1;
        wait_for_results();
      end
      chars.delete();
      pick = $urandom_range(99);
      if (pick < 20) begin
        repeat ($urandom_range(1, 6)) chars.push_back(8'($urandom_range(0, 255)));
        last_end = ($urandom_range(3) == 0);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(4))
            0: chars.push_back(8'($urandom_range(0, 127)));
            1: begin
              chars.push_back(8'hC0 | 8'($urandom_range(0, 31)));
              chars.push_back(follower());
            end
            2: begin
              chars.push_back(8'hE0 | 8'($urandom_range(0, 15)));
              repeat (2) chars.push_back(follower());
            end
            3: begin
              chars.push_back(8'hF0 | 8'($urandom_range(0, 7)));
              repeat (3) chars.push_back(follower());
            end
            default: begin
              if ($urandom_range(1) == 0) chars.push_back(8'h80 | 8'($urandom_range(0, 63)));
              else chars.push_back(8'hF8 | 8'($urandom_range(0, 7)));
            end
          endcase
        end
        last_end = 1'b1;
      end
      nsend = chars.size();
      if (pick >= 20 && pick < 45 && nsend > 1) nsend = $urandom_range(1, nsend - 1);
      for (i = 0; i < nsend; i++) put_byte(chars[i], (i == nsend - 1) ? last_end : 1'b0);
    end

    wait_for_results();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[utf8_codepoint_decoder] OK");
    end else begin
      $display("[utf8_codepoint_decoder] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
